// ===== hdl/ems_page_mapper_defines.svh =====
// assertion macros for the ems page mapper
// expects clk and rst_n in the scope where a macro is used
`ifndef EMS_PAGE_MAPPER_DEFINES_SVH
`define EMS_PAGE_MAPPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EMSPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define EMSPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/emspm_pkg.sv =====
// shared types and constants for the ems page mapper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package emspm_pkg;

  localparam int EMSPM_PAGE_COUNT = 32;
  localparam int CFG_DATA_W       = 15;
  localparam int CFG_IDX_W        = 2;

  // request modes
  localparam logic [1:0] MODE_PORT_WR = 2'd0;
  localparam logic [1:0] MODE_PORT_RD = 2'd1;
  localparam logic [1:0] MODE_XLATE   = 2'd2;

  // port offsets
  localparam logic [1:0] OFFS_PAGE_LO = 2'd0;
  localparam logic [1:0] OFFS_PAGE_HI = 2'd1;
  localparam logic [1:0] OFFS_INDEX   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMS_CONTROL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAM_CONFIG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_BOUNDARY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE_KB = 2'd3;

  localparam logic [7:0]  RST_EMS_CONTROL  = 8'h00;
  localparam logic [7:0]  RST_DRAM_CONFIG  = 8'h02;
  localparam logic [7:0]  RST_EXT_BOUNDARY = 8'h00;
  localparam logic [14:0] RST_MEM_SIZE_KB  = 15'd2048;

  localparam logic [7:0] PAGE_LO_RESET = 8'hFF;
  localparam logic [7:0] PAGE_HI_RESET = 8'h03;
  localparam logic [7:0] PORT_IDLE_DATA = 8'hFF;
  localparam logic [7:0] PORT_EN_MASK  = 8'h41;
  localparam logic [7:0] PORT_EN_BASE  = 8'h40;

  // page windows in 16 KB block numbers
  localparam logic [9:0] WIN_LO_FIRST = 10'd16;
  localparam logic [9:0] WIN_LO_END   = 10'd40;
  localparam logic [9:0] WIN_HI_FIRST = 10'd52;
  localparam logic [9:0] WIN_HI_END   = 10'd60;
  localparam logic [9:0] WIN_HI_BASE  = 10'd28;

  // remap constants
  localparam logic [23:0] RM_MASK_HI    = 24'h780000;
  localparam logic [23:0] RM_MASK_TOP   = 24'h600000;
  localparam logic [23:0] RM_MASK_MID   = 24'h180000;
  localparam logic [23:0] RM_SWAP_LO    = 24'h100000;
  localparam logic [23:0] RM_SWAP_END   = 24'h160000;
  localparam logic [23:0] RM_XOR_SMALL  = 24'h1F0000;
  localparam logic [23:0] RM_XOR_LARGE  = 24'h670000;
  localparam logic [14:0] MEM_2M_KB     = 15'd2048;
  localparam logic [3:0]  DRAM_CODE_SWAP = 4'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic        port_bank;
    logic [1:0]  port_offset;
    logic [7:0]  data_byte;
    logic [23:0] cpu_addr;
  } emspm_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [23:0] phys_addr;
    logic        in_range;
    logic        page_hit;
  } emspm_out_t;

endpackage

`default_nettype wire

// ===== hdl/emspm_remap.sv =====
// dram configuration remap, extended memory swap and range check
// depends on emspm_pkg
`timescale 1ns / 1ps
`default_nettype none

module emspm_remap (
  input  wire logic [23:0] addr_in,
  input  wire logic [3:0]  dram_code,
  input  wire logic        ext_flag,
  input  wire logic [14:0] mem_size_kb,
  output logic      [23:0] phys_addr,
  output logic             in_range
);
  import emspm_pkg::*;

  logic        size_lt;
  logic        size_gt;
  logic        size_eq;
  logic [23:0] addr_rm;
  logic [23:0] addr_low;
  logic        in_swap;

  assign size_lt = mem_size_kb < MEM_2M_KB;
  assign size_gt = mem_size_kb > MEM_2M_KB;
  assign size_eq = mem_size_kb == MEM_2M_KB;

  always_comb begin
    addr_rm = addr_in;
    if (size_lt && (dram_code > 4'd7 || ext_flag)) begin
      addr_rm = (addr_in & ~RM_MASK_HI) | ((addr_in & RM_MASK_TOP) >> 2);
    end else if (dram_code < 4'd8 && !ext_flag) begin
      addr_rm = addr_in & ~RM_MASK_TOP;
      if (size_gt || (size_eq && dram_code < 4'd6)) begin
        addr_rm = addr_rm | ((addr_rm & RM_MASK_MID) << 2);
      end
    end
  end

  assign addr_low = addr_rm & ~RM_MASK_TOP;
  assign in_swap  = !ext_flag && (dram_code == DRAM_CODE_SWAP) &&
                    (addr_low >= RM_SWAP_LO) && (addr_low < RM_SWAP_END);

  assign phys_addr = in_swap ? (addr_rm ^ (size_lt ? RM_XOR_SMALL : RM_XOR_LARGE)) : addr_rm;
  assign in_range  = {1'b0, phys_addr} < {mem_size_kb, 10'd0};

endmodule

`default_nettype wire

// ===== hdl/ems_page_mapper.sv =====
// ems page mapper top level: page stores, index register, result register
// depends on emspm_pkg, emspm_remap and ems_page_mapper_defines.svh
`timescale 1ns / 1ps
`default_nettype none

// One request per clock while the output is not stalled. A request is
// accepted into a first stage register, where the page store memory is read
// (one port, registered data) and port writes land; the result register is
// then loaded from the first stage when the output can advance, and the
// result is presented from there. A stalled output holds both stages. The
// page stores come out of reset at 0xFF (low) and 0x03 (high) through
// per-entry valid bits, so there is no clearing pass after reset.
// Configuration may be written only while no request is in flight.
`include "ems_page_mapper_defines.svh"

module ems_page_mapper #(
  parameter int PAGE_COUNT = emspm_pkg::EMSPM_PAGE_COUNT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire emspm_pkg::emspm_in_t                in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output emspm_pkg::emspm_out_t                    out_data,
  input  wire logic                                cfg_we,
  input  wire logic [emspm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [emspm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import emspm_pkg::*;

  localparam int PAGE_AW = $clog2(PAGE_COUNT);

  // configuration
  logic [7:0]  ems_control_r;
  logic [7:0]  dram_config_r;
  logic [7:0]  ext_boundary_r;
  logic [14:0] mem_size_kb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ems_control_r  <= RST_EMS_CONTROL;
      dram_config_r  <= RST_DRAM_CONFIG;
      ext_boundary_r <= RST_EXT_BOUNDARY;
      mem_size_kb_r  <= RST_MEM_SIZE_KB;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMS_CONTROL:  ems_control_r  <= cfg_wdata[7:0];
        REG_DRAM_CONFIG:  dram_config_r  <= cfg_wdata[7:0];
        REG_EXT_BOUNDARY: ext_boundary_r <= cfg_wdata[7:0];
        REG_MEM_SIZE_KB:  mem_size_kb_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_vld_r;
  logic out_vld_r;
  logic s1_adv;
  logic in_fire;

  assign s1_adv   = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) s1_vld_r <= in_valid;
      if (s1_adv) out_vld_r <= s1_vld_r;
    end
  end

  // port decode at acceptance
  logic               port_en;
  logic [PAGE_AW-1:0] sel;
  logic [9:0]         blk;
  logic [9:0]         blk_off;
  logic               win_lo;
  logic               win_hi;
  logic [PAGE_AW-1:0] raddr;
  logic               wr_lo;
  logic               wr_hi;
  logic [7:0]         page_index_r;
  logic [7:0]         page_index_nxt;

  assign port_en = (ems_control_r & PORT_EN_MASK) == (PORT_EN_BASE | {7'd0, in_data.port_bank});
  assign sel     = page_index_r[PAGE_AW-1:0];
  assign blk     = in_data.cpu_addr[23:14];
  assign win_lo  = (blk >= WIN_LO_FIRST) && (blk < WIN_LO_END);
  assign win_hi  = (blk >= WIN_HI_FIRST) && (blk < WIN_HI_END);
  assign blk_off = win_lo ? (blk - WIN_LO_FIRST) : (blk - WIN_HI_BASE);
  assign raddr   = (in_data.mode == MODE_XLATE) ? blk_off[PAGE_AW-1:0] : sel;

  assign wr_lo = in_fire && port_en && (in_data.mode == MODE_PORT_WR) &&
                 (in_data.port_offset == OFFS_PAGE_LO);
  assign wr_hi = in_fire && port_en && (in_data.mode == MODE_PORT_WR) &&
                 (in_data.port_offset == OFFS_PAGE_HI);

  always_comb begin
    page_index_nxt = page_index_r;
    if (in_fire && port_en && in_data.mode == MODE_PORT_WR) begin
      if (in_data.port_offset == OFFS_INDEX) begin
        page_index_nxt = in_data.data_byte;
      end else if (in_data.port_offset == OFFS_PAGE_HI && page_index_r[7]) begin
        page_index_nxt = {page_index_r[7:5], page_index_r[4:0] + 5'd1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_index_r <= 8'd0;
    end else begin
      page_index_r <= page_index_nxt;
    end
  end

  // page stores with valid bits standing in for the reset values
  logic [7:0]            lo_mem [PAGE_COUNT];
  logic [7:0]            hi_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] lo_vld_r;
  logic [PAGE_COUNT-1:0] hi_vld_r;
  logic [7:0]            lo_rd_r;
  logic [7:0]            hi_rd_r;
  logic                  lo_rv_r;
  logic                  hi_rv_r;

  always_ff @(posedge clk) begin
    if (wr_lo) lo_mem[sel] <= in_data.data_byte;
    if (wr_hi) hi_mem[sel] <= in_data.data_byte;
    if (in_fire) begin
      lo_rd_r <= lo_mem[raddr];
      hi_rd_r <= hi_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_vld_r <= '0;
      hi_vld_r <= '0;
      lo_rv_r  <= 1'b0;
      hi_rv_r  <= 1'b0;
    end else begin
      if (wr_lo) lo_vld_r[sel] <= 1'b1;
      if (wr_hi) hi_vld_r[sel] <= 1'b1;
      if (in_fire) begin
        lo_rv_r <= lo_vld_r[raddr];
        hi_rv_r <= hi_vld_r[raddr];
      end
    end
  end

  // first stage payload
  logic [1:0]  s1_mode_r;
  logic [1:0]  s1_offs_r;
  logic        s1_port_en_r;
  logic        s1_win_r;
  logic [23:0] s1_addr_r;
  logic [7:0]  s1_index_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_data.mode;
      s1_offs_r    <= in_data.port_offset;
      s1_port_en_r <= port_en;
      s1_win_r     <= win_lo || win_hi;
      s1_addr_r    <= in_data.cpu_addr;
      s1_index_r   <= page_index_r;
    end
  end

  // second stage: page lookup, remap, result
  logic [7:0]  page_lo;
  logic [7:0]  page_hi;
  logic        hit;
  logic [23:0] mapped_addr;
  logic [23:0] phys;
  logic        phys_in_range;
  emspm_out_t  out_data_nxt;
  emspm_out_t  out_data_r;

  assign page_lo     = lo_rv_r ? lo_rd_r : PAGE_LO_RESET;
  assign page_hi     = hi_rv_r ? hi_rd_r : PAGE_HI_RESET;
  assign hit         = s1_win_r && ems_control_r[7] && page_hi[7];
  assign mapped_addr = hit ? {page_hi[1:0], page_lo, s1_addr_r[13:0]} : s1_addr_r;

  emspm_remap u_remap (
    .addr_in     (mapped_addr),
    .dram_code   (dram_config_r[3:0]),
    .ext_flag    (ext_boundary_r[6]),
    .mem_size_kb (mem_size_kb_r),
    .phys_addr   (phys),
    .in_range    (phys_in_range)
  );

  always_comb begin
    out_data_nxt = '0;
    case (s1_mode_r)
      MODE_PORT_RD: begin
        out_data_nxt.read_data = PORT_IDLE_DATA;
        if (s1_port_en_r) begin
          case (s1_offs_r)
            OFFS_PAGE_LO: out_data_nxt.read_data = page_lo;
            OFFS_PAGE_HI: out_data_nxt.read_data = page_hi;
            OFFS_INDEX:   out_data_nxt.read_data = s1_index_r;
            default:      out_data_nxt.read_data = PORT_IDLE_DATA;
          endcase
        end
      end
      MODE_XLATE: begin
        out_data_nxt.phys_addr = phys;
        out_data_nxt.in_range  = phys_in_range;
        out_data_nxt.page_hit  = hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // checks
  `EMSPM_ASSERT_NOW(a_ready_when_empty, !out_vld_r, in_ready, "input stalled with empty output")
  `EMSPM_ASSERT_NOW(a_hit_needs_ems, out_vld_r && out_data_r.page_hit, ems_control_r[7], "page hit with ems off")
  `EMSPM_ASSERT_NOW(a_read_excl, out_vld_r && out_data_r.read_data != 8'd0, out_data_r.phys_addr == 24'd0 && !out_data_r.page_hit && !out_data_r.in_range, "port read result carries address")
  `EMSPM_ASSERT_NEXT(a_auto_inc, wr_hi && page_index_r[7], page_index_r[4:0] == $past(page_index_r[4:0]) + 5'd1, "index did not advance")

endmodule

`default_nettype wire
